// ===== rtl/core/lpfs_pkg.sv =====
package lpfs_pkg;

   localparam int PIXEL_COUNT = 256;
   localparam int WORD_BITS   = 64;
   localparam int WORD_COUNT  = PIXEL_COUNT / WORD_BITS;

   localparam int SLOT_W      = $clog2(PIXEL_COUNT);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_NUM_W  = 2;
   localparam int INDEX_W     = 8;
   localparam int VALUE_W     = 8;
   localparam int LEVEL_W     = 3;
   localparam int STEP_W      = 3;
   localparam int DUTY_W      = 8;
   localparam int TICKS_W     = 16;
   localparam int DELAY_W     = 23;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd300;
   localparam logic [DUTY_W-1:0]  MAX_DUTY    = 8'd128;
   localparam logic [STEP_W-1:0]  LAST_STEP   = 3'd7;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] pixel_index;
      logic [LEVEL_W-1:0] level;
   } job_type;

   // Frame duty for each brightness level; the top level is always on.
   function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
      logic [DUTY_W-1:0] duty;
      unique case (level)
         3'd0: duty = 8'd0;
         3'd1: duty = 8'd1;
         3'd2: duty = 8'd3;
         3'd3: duty = 8'd10;
         3'd4: duty = 8'd25;
         3'd5: duty = 8'd54;
         3'd6: duty = 8'd72;
         3'd7: duty = MAX_DUTY;
         default: duty = 8'd0;
      endcase
      return duty;
   endfunction

   // Chain slot to logical pixel. The chain snakes through pairs of rows:
   // the first half of each 16-slot run counts down, the second half up, and
   // the rows of a pair swap places on every other pair.
   function automatic logic [INDEX_W-1:0] slot_to_pixel(input logic [SLOT_W-1:0] slot);
      logic       half;
      logic [2:0] pos;
      half = slot[3];
      pos  = slot[2:0];
      return {slot[7:5], half, ~(slot[4] ^ slot[5]), (half ? pos : ~pos)};
   endfunction

endpackage

// ===== rtl/core/lpfs_if.sv =====
interface lpfs_req_if import lpfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [INDEX_W-1:0] pixel_index;
   logic [VALUE_W-1:0] pixel_value;

   modport source (output valid, command, pixel_index, pixel_value, input ready);
   modport sink (input valid, command, pixel_index, pixel_value, output ready);
endinterface

interface lpfs_rsp_if import lpfs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  frame_bits;
   logic [WORD_NUM_W-1:0] word_number;
   logic                  latch_after;
   logic [DELAY_W-1:0]    frame_delay;

   modport source (output valid, frame_bits, word_number, latch_after, frame_delay,
                   input ready);
   modport sink (input valid, frame_bits, word_number, latch_after, frame_delay,
                 output ready);
endinterface

// ===== rtl/core/lpfs_ram.sv =====
module lpfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lpfs_front.sv =====
module lpfs_front import lpfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   lpfs_req_if.sink req_bus,
   output logic    job_valid,
   output job_type job,
   input  logic    job_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;
   job_type          new_job;

   // Only the top bits of a pixel value survive as its level.
   always_comb begin
      new_job.command     = req_bus.command;
      new_job.pixel_index = req_bus.pixel_index;
      new_job.level       = req_bus.pixel_value[VALUE_W-1 -: LEVEL_W];
   end

   assign req_bus.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign job_valid     = (count_ff != '0);
   assign job           = entry_ff[head_ff];
   assign pop           = job_valid && job_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[tail_ff] <= new_job;
      end
   end

endmodule

// ===== rtl/core/lpfs_back.sv =====
module lpfs_back import lpfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [TICKS_W-1:0] csr_write_data,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_ready,
   lpfs_rsp_if.source         rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic                  pend_ff, pend_in;
   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic [DUTY_W-1:0]     now_duty_ff, now_duty_in;
   logic [DELAY_W-1:0]    delay_ff, delay_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [TICKS_W-1:0]    ticks_ff;
   logic [PIXEL_COUNT-1:0] written_ff, written_in;
   logic                  lvl_written_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  rsp_bits_ff, rsp_bits_in;
   logic [WORD_NUM_W-1:0] rsp_word_ff, rsp_word_in;
   logic                  rsp_latch_ff, rsp_latch_in;
   logic [DELAY_W-1:0]    rsp_delay_ff, rsp_delay_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_addr;
   logic [LEVEL_W-1:0]    ram_rd_data;
   logic [LEVEL_W-1:0]    level;
   logic                  led_on;
   logic [STEP_W-1:0]     next_step;
   logic [DUTY_W-1:0]     next_duty;
   logic [DUTY_W-1:0]     cur_duty;
   logic [DUTY_W+TICKS_W-1:0] product;
   logic [WORD_BITS-1:0]  full_word;
   logic [SLOT_W-BIT_W-1:0] word_index;
   logic                  last_word;
   logic                  out_free;

   lpfs_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (PIXEL_COUNT)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (job.pixel_index),
      .wr_data (job.level),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A pixel never written since reset reads as level zero.
   assign level  = lvl_written_ff ? ram_rd_data : '0;
   assign led_on = (now_duty_ff < duty_of(level));

   assign cur_duty  = duty_of(step_ff);
   assign next_step = (step_ff == LAST_STEP) ? LAST_STEP : step_ff + 1'b1;
   assign next_duty = duty_of(next_step);
   assign product   = (next_duty - cur_duty) * ticks_ff;

   assign word_index = pend_slot_ff[SLOT_W-1:BIT_W];
   assign last_word  = (word_index == (SLOT_W-BIT_W)'(WORD_COUNT - 1));
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      full_word = acc_ff;
      full_word[pend_slot_ff[BIT_W-1:0]] = led_on;
   end

   assign job_ready   = (state_ff == ST_IDLE);
   assign ram_wr_en   = (state_ff == ST_IDLE) && job_valid && (job.command == CMD_WRITE);
   assign ram_rd_en   = (state_ff == ST_READ);
   assign ram_rd_addr = slot_to_pixel(slot_ff);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      pend_slot_in = pend_slot_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      now_duty_in  = now_duty_ff;
      delay_in     = delay_ff;
      step_in      = step_ff;
      written_in   = written_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_latch_in = rsp_latch_ff;
      rsp_delay_in = rsp_delay_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job.command == CMD_WRITE) begin
                  written_in[job.pixel_index] = 1'b1;
               end else begin
                  now_duty_in = cur_duty;
                  delay_in    = product[DELAY_W-1:0];
                  step_in     = (next_duty >= MAX_DUTY) ? '0 : next_step;
                  slot_in     = '0;
                  pend_in     = 1'b0;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            // The level read in the previous cycle lands in the word here.
            if (pend_ff) begin
               acc_in = full_word;
            end
            pend_in      = 1'b1;
            pend_slot_in = slot_ff;
            slot_in      = slot_ff + 1'b1;
            if (slot_ff[BIT_W-1:0] == {BIT_W{1'b1}}) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = full_word;
               rsp_word_in  = WORD_NUM_W'(word_index);
               rsp_latch_in = last_word;
               rsp_delay_in = delay_ff;
               pend_in      = 1'b0;
               state_in     = last_word ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         step_ff      <= '0;
         ticks_ff     <= TICKS_RESET;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         step_ff      <= step_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ticks_ff <= csr_write_data;
         end
      end
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
      acc_ff       <= acc_in;
      now_duty_ff  <= now_duty_in;
      delay_ff     <= delay_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_latch_ff <= rsp_latch_in;
      rsp_delay_ff <= rsp_delay_in;
      if (ram_rd_en) begin
         lvl_written_ff <= written_ff[ram_rd_addr];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.frame_bits  = rsp_bits_ff;
   assign rsp_bus.word_number = rsp_word_ff;
   assign rsp_bus.latch_after = rsp_latch_ff;
   assign rsp_bus.frame_delay = rsp_delay_ff;

endmodule

// ===== rtl/core/led_panel_pwm_frame_scanner_core.sv =====
// PWM frame scanner for a 16x16 LED panel on a 256-bit shift chain. A write
// transaction stores the top three bits of a pixel value as that pixel's
// level; a render transaction produces four 64-bit chain words, slot 0
// first, with latch_after set on the last, each carrying the timer delay to
// the next frame. A render is paced by the level memory's single read port,
// which delivers one chain slot per cycle while a word is read; each word is
// then handed over in a flush step that waits while the result side stalls.
// A two-entry queue in front lets new transactions be taken while a render
// runs. The level store reads as zero after reset without a clearing pass.
module led_panel_pwm_frame_scanner_core import lpfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   lpfs_req_if.sink           req_bus,
   lpfs_rsp_if.source         rsp_bus,
   input  logic               csr_write_enable,
   input  logic [TICKS_W-1:0] csr_write_data
);

   logic    job_valid;
   logic    job_ready;
   job_type job;

   lpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   lpfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_valid        (job_valid),
      .job              (job),
      .job_ready        (job_ready),
      .rsp_bus          (rsp_bus)
   );

endmodule
